[sv/i2cbb_pkg.sv]
package i2cbb_pkg;

    localparam int SEQ_DEPTH  = 1024;
    localparam int IDX_W      = $clog2(SEQ_DEPTH);
    localparam int ENTRY_W    = 10;
    localparam int PC_W       = 6;
    localparam int FRAME_BITS = 9;
    localparam int CNT_W      = $clog2(FRAME_BITS + 1);

    typedef logic [PC_W-1:0]  pc_t;
    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [2:0] {
        CMD_OPEN     = 3'd0,
        CMD_WRITE    = 3'd1,
        CMD_CLOSE_WR = 3'd2,
        CMD_RESTART  = 3'd3,
        CMD_READ     = 3'd4,
        CMD_CLOSE_RD = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        SDA_ZERO,
        SDA_ONE,
        SDA_NPREV,
        SDA_NBIT,
        SDA_NSPV
    } sda_sel_t;

    typedef enum logic [2:0] {
        JMP_NONE,
        JMP_STARTED,
        JMP_SPV_HI,
        JMP_SPV_LO,
        JMP_CNT_NOT1
    } jmp_t;

    typedef enum logic [1:0] {
        SPV_KEEP,
        SPV_ONE,
        SPV_NBIT
    } spv_op_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } seq_state_t;

    // program entry points and jump targets
    localparam pc_t PC_OPEN       = PC_W'(0);
    localparam pc_t PC_OPEN_START = PC_W'(4);
    localparam pc_t PC_OPEN_BIT   = PC_W'(5);
    localparam pc_t PC_WRITE      = PC_W'(8);
    localparam pc_t PC_CLOSE_WR   = PC_W'(11);
    localparam pc_t PC_CW_LOW     = PC_W'(13);
    localparam pc_t PC_RESTART    = PC_W'(15);
    localparam pc_t PC_RS_LOW     = PC_W'(17);
    localparam pc_t PC_RS_BIT     = PC_W'(19);
    localparam pc_t PC_READ       = PC_W'(22);
    localparam pc_t PC_CLOSE_RD   = PC_W'(29);

    typedef struct packed {
        sda_sel_t sda_sel;
        logic     scl;
        logic     rc;
        logic     busy;
        logic     next_zero;
        logic     adv;
        logic     shift;
        logic     set_started;
        logic     fin;
        jmp_t     jmp;
        pc_t      target;
        spv_op_t  spv;
    } uword_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic [6:0] slave_addr;
        logic [7:0] data_byte;
        logic       last_byte;
    } req_t;

    typedef struct packed {
        logic [ENTRY_W-1:0] entry_index;
        logic [ENTRY_W-1:0] next_index;
        logic               read_capture;
        logic               sda_low;
        logic               scl_bit;
        logic               bus_busy;
        logic               last;
    } ent_t;

    typedef struct packed {
        logic started;
        logic spv;
        logic cnt_not1;
        logic out_free;
    } dp_status_t;

    typedef struct packed {
        logic load;
        logic step;
        logic taken;
        logic done;
    } seq_ctl_t;

    function automatic pc_t entry_pc(input logic [2:0] cmd);
        pc_t pc;
        unique case (cmd_t'(cmd))
            CMD_OPEN:     pc = PC_OPEN;
            CMD_WRITE:    pc = PC_WRITE;
            CMD_CLOSE_WR: pc = PC_CLOSE_WR;
            CMD_RESTART:  pc = PC_RESTART;
            CMD_READ:     pc = PC_READ;
            CMD_CLOSE_RD: pc = PC_CLOSE_RD;
            default:      pc = PC_OPEN;
        endcase
        return pc;
    endfunction

endpackage

[sv/i2cbb_rom.sv]
module i2cbb_rom import i2cbb_pkg::*; (
    input  pc_t    pc,
    output uword_t uw
);

    always_comb
    begin
        uw             = '0;
        uw.sda_sel     = SDA_ZERO;
        uw.jmp         = JMP_NONE;
        uw.spv         = SPV_KEEP;
        uw.target      = PC_OPEN;
        uw.busy        = 1'b1;
        uw.adv         = 1'b1;
        unique case (pc)
            // open: bus free, busy, optional dummy start/stop, start, address, write bit, ack
            PC_W'(0):
            begin
                uw.busy      = 1'b0;
                uw.next_zero = 1'b1;
            end
            PC_W'(1):
            begin
                uw.jmp    = JMP_STARTED;
                uw.target = PC_OPEN_START;
            end
            PC_W'(2): uw.sda_sel = SDA_ONE;
            PC_W'(3): uw.set_started = 1'b1;
            PC_W'(4): uw.sda_sel = SDA_ONE;
            PC_W'(5):
            begin
                uw.sda_sel = SDA_NPREV;
                uw.scl     = 1'b1;
            end
            PC_W'(6):
            begin
                uw.sda_sel = SDA_NBIT;
                uw.scl     = 1'b1;
            end
            PC_W'(7):
            begin
                uw.sda_sel = SDA_NBIT;
                uw.shift   = 1'b1;
                uw.jmp     = JMP_CNT_NOT1;
                uw.target  = PC_OPEN_BIT;
                uw.fin     = 1'b1;
                uw.spv     = SPV_ONE;
            end
            // write byte
            PC_W'(8):
            begin
                uw.sda_sel = SDA_NPREV;
                uw.scl     = 1'b1;
            end
            PC_W'(9):
            begin
                uw.sda_sel = SDA_NBIT;
                uw.scl     = 1'b1;
            end
            PC_W'(10):
            begin
                uw.sda_sel = SDA_NBIT;
                uw.shift   = 1'b1;
                uw.jmp     = JMP_CNT_NOT1;
                uw.target  = PC_WRITE;
                uw.fin     = 1'b1;
                uw.spv     = SPV_ONE;
            end
            // close write
            PC_W'(11):
            begin
                uw.sda_sel = SDA_NSPV;
                uw.scl     = 1'b1;
                uw.jmp     = JMP_SPV_LO;
                uw.target  = PC_CW_LOW;
            end
            PC_W'(12):
            begin
                uw.sda_sel = SDA_ONE;
                uw.scl     = 1'b1;
            end
            PC_W'(13): uw.sda_sel = SDA_ONE;
            PC_W'(14):
            begin
                uw.next_zero = 1'b1;
                uw.adv       = 1'b0;
                uw.fin       = 1'b1;
                uw.spv       = SPV_ONE;
            end
            // restart read
            PC_W'(15):
            begin
                uw.sda_sel = SDA_NSPV;
                uw.scl     = 1'b1;
                uw.jmp     = JMP_SPV_HI;
                uw.target  = PC_RS_LOW;
            end
            PC_W'(16): uw.scl = 1'b1;
            PC_W'(17): uw.sda_sel = SDA_ZERO;
            PC_W'(18): uw.sda_sel = SDA_ONE;
            PC_W'(19):
            begin
                uw.sda_sel = SDA_NPREV;
                uw.scl     = 1'b1;
            end
            PC_W'(20):
            begin
                uw.sda_sel = SDA_NBIT;
                uw.scl     = 1'b1;
            end
            PC_W'(21):
            begin
                uw.sda_sel = SDA_NBIT;
                uw.shift   = 1'b1;
                uw.jmp     = JMP_CNT_NOT1;
                uw.target  = PC_RS_BIT;
                uw.fin     = 1'b1;
                uw.spv     = SPV_ONE;
            end
            // read byte: eight data bits with capture, then ack or nack
            PC_W'(22):
            begin
                uw.sda_sel = SDA_NPREV;
                uw.scl     = 1'b1;
            end
            PC_W'(23):
            begin
                uw.sda_sel = SDA_NBIT;
                uw.scl     = 1'b1;
            end
            PC_W'(24):
            begin
                uw.sda_sel = SDA_NBIT;
                uw.shift   = 1'b1;
            end
            PC_W'(25):
            begin
                uw.rc     = 1'b1;
                uw.jmp    = JMP_CNT_NOT1;
                uw.target = PC_READ;
            end
            PC_W'(26):
            begin
                uw.sda_sel = SDA_NPREV;
                uw.scl     = 1'b1;
            end
            PC_W'(27):
            begin
                uw.sda_sel = SDA_NBIT;
                uw.scl     = 1'b1;
            end
            PC_W'(28):
            begin
                uw.sda_sel = SDA_NBIT;
                uw.shift   = 1'b1;
                uw.fin     = 1'b1;
                uw.spv     = SPV_NBIT;
            end
            // close read
            PC_W'(29): uw.scl = 1'b1;
            PC_W'(30):
            begin
                uw.sda_sel = SDA_ONE;
                uw.scl     = 1'b1;
            end
            PC_W'(31): uw.sda_sel = SDA_ONE;
            PC_W'(32):
            begin
                uw.next_zero = 1'b1;
                uw.adv       = 1'b0;
                uw.fin       = 1'b1;
                uw.spv       = SPV_ONE;
            end
            default:
            begin
                uw.fin = 1'b1;
                uw.adv = 1'b0;
            end
        endcase
    end

endmodule

[sv/i2cbb_seq.sv]
module i2cbb_seq import i2cbb_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    input  logic [2:0] req_cmd,
    output logic       req_ready,
    input  uword_t     uw,
    input  dp_status_t st,
    output pc_t        pc,
    output seq_ctl_t   ctl
);

    seq_state_t state_reg, state_next;
    pc_t        pc_reg, pc_next;
    logic       cmd_ok;
    logic       accept;
    logic       taken;

    assign cmd_ok = (req_cmd <= 3'(CMD_CLOSE_RD));
    assign pc     = pc_reg;

    always_comb
    begin
        unique case (uw.jmp)
            JMP_NONE:     taken = 1'b0;
            JMP_STARTED:  taken = st.started;
            JMP_SPV_HI:   taken = st.spv;
            JMP_SPV_LO:   taken = ~st.spv;
            JMP_CNT_NOT1: taken = st.cnt_not1;
            default:      taken = 1'b0;
        endcase
    end

    // outputs
    always_comb
    begin
        req_ready = (state_reg == ST_IDLE);
        accept    = req_ready && req_valid;
        ctl.load  = accept;
        ctl.step  = (state_reg == ST_RUN) && st.out_free;
        ctl.taken = taken;
        ctl.done  = ctl.step && uw.fin && !taken;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (req_valid && cmd_ok)
                begin
                    state_next = ST_RUN;
                end
            ST_RUN:
                if (ctl.done)
                begin
                    state_next = ST_IDLE;
                end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        pc_next = pc_reg;
        if (accept)
        begin
            pc_next = entry_pc(req_cmd);
        end
        else if (ctl.step)
        begin
            pc_next = taken ? uw.target : pc_reg + PC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pc_reg    <= PC_OPEN;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

endmodule

[sv/i2cbb_dp.sv]
module i2cbb_dp import i2cbb_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  req_t       req,
    input  uword_t     uw,
    input  seq_ctl_t   ctl,
    output dp_status_t st,
    output ent_t       ent,
    output logic       ent_valid,
    input  logic       ent_ready
);

    idx_t                  idx_reg, idx_next;
    idx_t                  idx_inc;
    logic [FRAME_BITS-1:0] shreg_reg, shreg_next;
    cnt_t                  cnt_reg, cnt_next;
    logic                  prev_reg, prev_next;
    logic                  spv_reg, spv_next;
    logic                  started_reg, started_next;
    ent_t                  ent_reg, ent_next;
    logic                  ent_valid_reg, ent_valid_next;
    logic                  bit_cur;
    logic                  sda;

    assign bit_cur = shreg_reg[FRAME_BITS-1];
    assign idx_inc = (idx_reg == IDX_W'(SEQ_DEPTH - 1)) ? '0 : idx_reg + IDX_W'(1);

    assign st.started  = started_reg;
    assign st.spv      = spv_reg;
    assign st.cnt_not1 = (cnt_reg != CNT_W'(1));
    assign st.out_free = !ent_valid_reg || ent_ready;

    assign ent       = ent_reg;
    assign ent_valid = ent_valid_reg;

    always_comb
    begin
        unique case (uw.sda_sel)
            SDA_ZERO:  sda = 1'b0;
            SDA_ONE:   sda = 1'b1;
            SDA_NPREV: sda = ~prev_reg;
            SDA_NBIT:  sda = ~bit_cur;
            SDA_NSPV:  sda = ~spv_reg;
            default:   sda = 1'b0;
        endcase
    end

    always_comb
    begin
        idx_next       = idx_reg;
        shreg_next     = shreg_reg;
        cnt_next       = cnt_reg;
        prev_next      = prev_reg;
        spv_next       = spv_reg;
        started_next   = started_reg;
        ent_next       = ent_reg;
        ent_valid_next = ent_valid_reg;

        if (ent_ready)
        begin
            ent_valid_next = 1'b0;
        end

        if (ctl.load)
        begin
            cnt_next = CNT_W'(FRAME_BITS);
            unique case (cmd_t'(req.cmd))
                CMD_OPEN:
                begin
                    shreg_next = {req.slave_addr, 1'b0, 1'b1};
                    prev_next  = 1'b0;
                    idx_next   = '0;
                end
                CMD_RESTART:
                begin
                    shreg_next = {req.slave_addr, 1'b1, 1'b1};
                    prev_next  = 1'b0;
                end
                CMD_READ:
                begin
                    shreg_next = {8'hFF, req.last_byte};
                    prev_next  = spv_reg;
                end
                default:
                begin
                    shreg_next = {req.data_byte, 1'b1};
                    prev_next  = spv_reg;
                end
            endcase
        end
        else if (ctl.step)
        begin
            ent_next.entry_index  = ENTRY_W'(idx_reg);
            ent_next.next_index   = uw.next_zero ? '0 : ENTRY_W'(idx_inc);
            ent_next.read_capture = uw.rc;
            ent_next.sda_low      = sda;
            ent_next.scl_bit      = uw.scl;
            ent_next.bus_busy     = uw.busy;
            ent_next.last         = ctl.done;
            ent_valid_next        = 1'b1;

            if (uw.adv)
            begin
                idx_next = idx_inc;
            end
            if (uw.shift)
            begin
                shreg_next = {shreg_reg[FRAME_BITS-2:0], 1'b0};
                prev_next  = bit_cur;
                cnt_next   = cnt_reg - CNT_W'(1);
            end
            if (uw.set_started)
            begin
                started_next = 1'b1;
            end
            if (ctl.done)
            begin
                unique case (uw.spv)
                    SPV_KEEP: spv_next = spv_reg;
                    SPV_ONE:  spv_next = 1'b1;
                    SPV_NBIT: spv_next = ~bit_cur;
                    default:  spv_next = spv_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            spv_reg       <= 1'b1;
            started_reg   <= 1'b0;
            ent_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            spv_reg       <= spv_next;
            started_reg   <= started_next;
            ent_valid_reg <= ent_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shreg_reg <= shreg_next;
        cnt_reg   <= cnt_next;
        prev_reg  <= prev_next;
        ent_reg   <= ent_next;
    end

endmodule

[sv/i2c_bitbang_sequence_builder.sv]
// I2C bit-bang sequence builder
// req channel: one command word (cmd, slave_addr, data_byte, last_byte) per
// transaction step; req_ready is high only while no command is in progress
// ent channel: one sequence table entry per word; the final entry of a
// command carries last
// a command is accepted and dispatched first, then takes one microcode step
// per entry
// open emits 32 or 30 entries, write byte 27, close 3 to 4, restart read
// 30 to 31, read byte 35; the microcode program counter steps once a cycle
// while the output register is free; the first step emits the first entry
// cmd 6 and 7 are accepted and dropped with no entries
// when ent_ready is low the sequencer holds its step until the output
// register is free, so no entry is lost or repeated
// reset clears the table position, the dummy start/stop flag and the
// sda level tracker (released); no command is pending after reset
module i2c_bitbang_sequence_builder import i2cbb_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic ent_valid,
    input  logic ent_ready,
    output ent_t ent
);

    pc_t        pc;
    uword_t     uw;
    dp_status_t st;
    seq_ctl_t   ctl;

    i2cbb_rom u_rom (
        .pc (pc),
        .uw (uw)
    );

    i2cbb_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_cmd   (req.cmd),
        .req_ready (req_ready),
        .uw        (uw),
        .st        (st),
        .pc        (pc),
        .ctl       (ctl)
    );

    i2cbb_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .uw        (uw),
        .ctl       (ctl),
        .st        (st),
        .ent       (ent),
        .ent_valid (ent_valid),
        .ent_ready (ent_ready)
    );

endmodule

[sim/i2c_bitbang_sequence_builder_tb.sv]
module i2c_bitbang_sequence_builder_tb import i2cbb_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    class entry_scoreboard;
        ent_t expected_q[$];
        int   fails;
        idx_t pos;
        bit   clk_high;
        bit   dummy_done;
        bit   sda_level;

        function new();
            fails      = 0;
            pos        = '0;
            clk_high   = 1'b0;
            dummy_done = 1'b0;
            sda_level  = 1'b1;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function idx_t step_pos();
            return idx_t'((int'(pos) + 1) % SEQ_DEPTH);
        endfunction

        function void push_entry(idx_t nxt_pos, bit rc, bit sda, bit scl, bit busy);
            ent_t e;
            e.entry_index  = ENTRY_W'(pos);
            e.next_index   = ENTRY_W'(nxt_pos);
            e.read_capture = rc;
            e.sda_low      = sda;
            e.scl_bit      = scl;
            e.bus_busy     = busy;
            e.last         = 1'b0;
            expected_q.push_back(e);
        endfunction

        function void put(bit rc, bit sda, bit scl);
            idx_t n;
            n = step_pos();
            push_entry(n, rc, sda, scl, 1'b1);
            pos = n;
        endfunction

        // old level with scl high, new level with scl high, then scl low
        function void drive_bit(bit old_b, bit new_b);
            put(1'b0, !old_b, 1'b1);
            put(1'b0, !new_b, 1'b1);
            put(1'b0, !new_b, 1'b0);
        endfunction

        function void start_cond(bit sda_hi);
            if (!sda_hi)
            begin
                if (!clk_high)
                begin
                    clk_high = 1'b1;
                    put(1'b0, 1'b1, 1'b1);
                end
                put(1'b0, 1'b0, 1'b1);
            end
            if (clk_high)
            begin
                clk_high = 1'b0;
                put(1'b0, 1'b0, 1'b0);
            end
            put(1'b0, 1'b1, 1'b0);
            clk_high = 1'b0;
        endfunction

        function void stop_cond(bit sda_hi, bit closing);
            if (sda_hi)
            begin
                if (!clk_high)
                begin
                    clk_high = 1'b1;
                    put(1'b0, 1'b0, 1'b1);
                end
                put(1'b0, 1'b1, 1'b1);
            end
            if (clk_high)
            begin
                clk_high = 1'b0;
                put(1'b0, 1'b1, 1'b0);
            end
            // closing entry keeps its position and points back to 0
            if (closing)
                push_entry('0, 1'b0, 1'b0, 1'b0, 1'b1);
            else
                put(1'b0, 1'b0, 1'b0);
        endfunction

        function void address(logic [6:0] addr, bit rw);
            bit p;
            bit b;
            p = 1'b0;
            for (int i = 0; i < 7; i++)
            begin
                b = addr[6 - i];
                drive_bit(p, b);
                p = b;
            end
            drive_bit(p, rw);
        endfunction

        function void raise_scl();
            put(1'b0, !sda_level, 1'b1);
            clk_high = 1'b1;
        endfunction

        function void note_command(req_t r);
            int   n0;
            bit   p;
            bit   b;
            ent_t e;
            n0 = expected_q.size();
            case (r.cmd)
                CMD_OPEN:
                begin
                    pos = '0;
                    push_entry(pos, 1'b0, 1'b0, 1'b0, 1'b0);
                    pos = step_pos();
                    put(1'b0, 1'b0, 1'b0);
                    clk_high = 1'b0;
                    if (!dummy_done)
                    begin
                        start_cond(1'b1);
                        stop_cond(1'b0, 1'b0);
                        dummy_done = 1'b1;
                    end
                    start_cond(1'b1);
                    address(r.slave_addr, 1'b0);
                    drive_bit(1'b0, 1'b1);
                    sda_level = 1'b1;
                end
                CMD_WRITE:
                begin
                    p = sda_level;
                    for (int i = 0; i < 8; i++)
                    begin
                        b = r.data_byte[7 - i];
                        drive_bit(p, b);
                        p = b;
                    end
                    drive_bit(p, 1'b1);
                    sda_level = 1'b1;
                end
                CMD_CLOSE_WR:
                begin
                    raise_scl();
                    stop_cond(sda_level, 1'b1);
                    sda_level = 1'b1;
                end
                CMD_RESTART:
                begin
                    raise_scl();
                    start_cond(sda_level);
                    address(r.slave_addr, 1'b1);
                    drive_bit(1'b1, 1'b1);
                    sda_level = 1'b1;
                end
                CMD_READ:
                begin
                    p = sda_level;
                    for (int i = 0; i < 8; i++)
                    begin
                        drive_bit(p, 1'b1);
                        put(1'b1, 1'b0, 1'b0);
                        p = 1'b1;
                    end
                    // nack on the final byte leaves the tracked level low
                    if (r.last_byte)
                    begin
                        drive_bit(p, 1'b1);
                        sda_level = 1'b0;
                    end
                    else
                    begin
                        drive_bit(p, 1'b0);
                        sda_level = 1'b1;
                    end
                end
                CMD_CLOSE_RD:
                begin
                    put(1'b0, 1'b0, 1'b1);
                    clk_high  = 1'b1;
                    sda_level = 1'b1;
                    stop_cond(1'b1, 1'b1);
                end
                default:
                begin
                end
            endcase
            if (expected_q.size() > n0)
            begin
                e = expected_q[expected_q.size() - 1];
                e.last = 1'b1;
                expected_q[expected_q.size() - 1] = e;
            end
        endfunction

        function void check_entry(ent_t got);
            ent_t w;
            if (expected_q.size() == 0)
            begin
                fails++;
                if (fails <= 10)
                    $display("unexpected entry idx %0d next %0d rc %b sda %b scl %b busy %b last %b",
                             got.entry_index, got.next_index, got.read_capture, got.sda_low,
                             got.scl_bit, got.bus_busy, got.last);
                return;
            end
            w = expected_q.pop_front();
            if (got.entry_index !== w.entry_index || got.next_index !== w.next_index ||
                got.read_capture !== w.read_capture || got.sda_low !== w.sda_low ||
                got.scl_bit !== w.scl_bit || got.bus_busy !== w.bus_busy ||
                got.last !== w.last)
            begin
                fails++;
                if (fails <= 10)
                begin
                    $display("entry mismatch at %0t", $realtime);
                    $display("  exp idx %0d next %0d rc %b sda %b scl %b busy %b last %b",
                             w.entry_index, w.next_index, w.read_capture, w.sda_low,
                             w.scl_bit, w.bus_busy, w.last);
                    $display("  got idx %0d next %0d rc %b sda %b scl %b busy %b last %b",
                             got.entry_index, got.next_index, got.read_capture, got.sda_low,
                             got.scl_bit, got.bus_busy, got.last);
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic ent_valid;
    logic ent_ready;
    ent_t ent;

    entry_scoreboard sb;
    int tx_idle_pct;
    int rx_stall_pct;
    int rx_hold_len;
    int items_sent;

    i2c_bitbang_sequence_builder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .ent_valid (ent_valid),
        .ent_ready (ent_ready),
        .ent       (ent)
    );

    always #1 clk = ~clk;

    function automatic req_t make_cmd(logic [2:0] c, logic [6:0] a, logic [7:0] d, logic l);
        req_t r;
        r.cmd        = c;
        r.slave_addr = a;
        r.data_byte  = d;
        r.last_byte  = l;
        return r;
    endfunction

    // called at a falling edge, returns at a falling edge with the word taken
    task automatic send_word(input req_t w);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= w;
        do
            @(posedge clk);
        while (!req_ready);
        sb.note_command(w);
        if (w.cmd <= CMD_CLOSE_RD)
            items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    task automatic send_rand(input logic [2:0] c);
        send_word(make_cmd(c, 7'($urandom), 8'($urandom), 1'($urandom)));
    endtask

    task automatic play_random();
        int n;
        if ($urandom_range(99) < 15)
        begin
            send_rand(3'($urandom_range(7)));
            return;
        end
        send_rand(CMD_OPEN);
        n = ($urandom_range(19) == 0) ? $urandom_range(30, 42) : $urandom_range(0, 4);
        repeat (n)
            send_rand(CMD_WRITE);
        if ($urandom_range(1))
        begin
            send_rand(CMD_RESTART);
            n = ($urandom_range(19) == 0) ? $urandom_range(28, 34) : $urandom_range(1, 4);
            for (int i = 0; i < n; i++)
                send_word(make_cmd(CMD_READ, 7'($urandom), 8'($urandom), i == n - 1));
            if ($urandom_range(9) != 0)
                send_rand(CMD_CLOSE_RD);
        end
        else if ($urandom_range(9) != 0)
            send_rand(CMD_CLOSE_WR);
    endtask

    // receiver side
    initial
    begin
        ent_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_len > 0)
            begin
                ent_ready <= 1'b0;
                rx_hold_len--;
            end
            else
                ent_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && ent_valid && ent_ready)
            sb.check_entry(ent);
    end

    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        int target;
        sb           = new();
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req          = '0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        rx_hold_len  = 0;
        items_sent   = 0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // close before any open, then a full write and read transaction
        send_word(make_cmd(CMD_CLOSE_WR, 7'h00, 8'h00, 1'b0));
        send_word(make_cmd(CMD_OPEN,     7'h7f, 8'hff, 1'b1));
        send_word(make_cmd(CMD_WRITE,    7'h00, 8'h00, 1'b0));
        send_word(make_cmd(CMD_WRITE,    7'h7f, 8'hff, 1'b1));
        send_word(make_cmd(CMD_WRITE,    7'h00, 8'ha5, 1'b0));
        send_word(make_cmd(CMD_RESTART,  7'h00, 8'h00, 1'b0));
        send_word(make_cmd(CMD_READ,     7'h00, 8'h00, 1'b0));
        send_word(make_cmd(CMD_READ,     7'h00, 8'h00, 1'b1));
        send_word(make_cmd(CMD_CLOSE_RD, 7'h00, 8'h00, 1'b0));
        // second open skips the dummy start/stop
        send_word(make_cmd(CMD_OPEN,     7'h00, 8'h00, 1'b0));
        send_word(make_cmd(CMD_WRITE,    7'h7f, 8'h5a, 1'b1));
        send_word(make_cmd(CMD_CLOSE_WR, 7'h7f, 8'hff, 1'b1));
        send_word(make_cmd(CMD_SPARE_6,  7'h7f, 8'hff, 1'b1));
        send_word(make_cmd(CMD_SPARE_7,  7'h7f, 8'hff, 1'b1));
        // out of order commands from whatever state is left
        send_word(make_cmd(CMD_READ,     7'h00, 8'h00, 1'b1));
        send_word(make_cmd(CMD_WRITE,    7'h00, 8'h3c, 1'b0));
        send_word(make_cmd(CMD_READ,     7'h00, 8'h00, 1'b1));
        send_word(make_cmd(CMD_RESTART,  7'h55, 8'h00, 1'b0));
        send_word(make_cmd(CMD_CLOSE_WR, 7'h00, 8'h00, 1'b0));
        send_word(make_cmd(CMD_CLOSE_RD, 7'h00, 8'h00, 1'b0));
        send_word(make_cmd(CMD_CLOSE_RD, 7'h00, 8'h00, 1'b0));
        send_word(make_cmd(CMD_OPEN,     7'h2a, 8'h00, 1'b0));
        send_word(make_cmd(CMD_CLOSE_WR, 7'h00, 8'h00, 1'b0));
        wait_drained();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                    rx_hold_len  = 400;
                end
                1:
                begin
                    tx_idle_pct  = 73;
                    rx_stall_pct = 0;
                end
                2:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 73;
                end
                default:
                begin
                    tx_idle_pct  = 30;
                    rx_stall_pct = 30;
                end
            endcase
            target = items_sent + 125;
            while (items_sent < target)
                play_random();
            wait_drained();
        end

        repeat (60) @(posedge clk);
        if (sb.fails == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
